### sv/bdl_pkg.sv
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared types, constants and pattern tables for the button debouncer and
// LED blinker.
// ----------------------------------------------------------------------------
package bdl_pkg;

    localparam int unsigned DEBOUNCE_TICKS_DEF = 6;
    localparam int unsigned PAT_W              = 8;
    localparam int unsigned BLINK_CNT_W        = 9;

    // Pattern codes; anything from PAT_STEADY upwards holds the LED on.
    localparam logic [PAT_W-1:0] PAT_SLOW       = 8'd0;
    localparam logic [PAT_W-1:0] PAT_MEDIUM     = 8'd1;
    localparam logic [PAT_W-1:0] PAT_FAST       = 8'd2;
    localparam logic [PAT_W-1:0] PAT_SHORT      = 8'd3;
    localparam logic [PAT_W-1:0] PAT_DOUBLE     = 8'd4;
    localparam logic [PAT_W-1:0] PAT_TRIPLE     = 8'd5;
    localparam logic [PAT_W-1:0] PAT_STEADY     = 8'd6;

    typedef logic [BLINK_CNT_W-1:0] t_blink_cnt;

    typedef struct packed {
        logic led_on;
        logic period_done;
    } t_blink_res;

    typedef struct packed {
        logic led_on;
        logic button_one_press;
        logic button_two_press;
        logic wake;
    } t_result;

    // LED level at a given position in the period of a pattern.
    function automatic logic lit_at(input logic [PAT_W-1:0] pat, input t_blink_cnt c);
        logic seg_a;
        logic seg_b;
        logic seg_c;
        seg_a = (c < 9'd50);
        seg_b = (c >= 9'd100) && (c < 9'd150);
        seg_c = (c >= 9'd200) && (c < 9'd250);
        case (pat)
            PAT_SLOW:   lit_at = (c < 9'd200);
            PAT_MEDIUM: lit_at = (c < 9'd75);
            PAT_FAST:   lit_at = (c < 9'd25);
            PAT_SHORT:  lit_at = seg_a;
            PAT_DOUBLE: lit_at = seg_a | seg_b;
            default:    lit_at = seg_a | seg_b | seg_c;
        endcase
    endfunction

    // Period length of a pattern, one bit wider than the counter.
    function automatic logic [BLINK_CNT_W:0] period_of(input logic [PAT_W-1:0] pat);
        case (pat)
            PAT_SLOW:   period_of = 10'd250;
            PAT_MEDIUM: period_of = 10'd150;
            PAT_FAST:   period_of = 10'd50;
            PAT_SHORT:  period_of = 10'd250;
            PAT_DOUBLE: period_of = 10'd350;
            default:    period_of = 10'd450;
        endcase
    endfunction

endpackage

### sv/bdl_debounce.sv
// ----------------------------------------------------------------------------
// bdl_debounce
// Saturating up/down counter debouncer with a latched pressed state.
// ----------------------------------------------------------------------------
module bdl_debounce import bdl_pkg::*; #(
    parameter int unsigned DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  logic i_level,
    output logic o_press
);

    localparam int unsigned CNT_W = $clog2(DEBOUNCE_TICKS);
    localparam logic [CNT_W-1:0] TOP = CNT_W'(DEBOUNCE_TICKS - 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_state;
    logic             n_state;

    always_comb begin
        n_cnt   = r_cnt;
        n_state = r_state;
        o_press = 1'b0;
        if (i_level) begin
            if (r_cnt == TOP && !r_state) begin
                n_state = 1'b1;
                o_press = 1'b1;
            end
            // The count cannot be both at the top and zero, so the set above
            // never meets this clear.
            if (r_cnt == '0 && r_state) begin
                n_state = 1'b0;
            end
            if (r_cnt < TOP) begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_state <= 1'b0;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_state <= n_state;
        end
    end

endmodule

### sv/bdl_blink.sv
// ----------------------------------------------------------------------------
// bdl_blink
// Pattern register and blink position counter; gives the LED level and the
// end-of-period pulse for each item.
// ----------------------------------------------------------------------------
module bdl_blink import bdl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr,
    input  logic [PAT_W-1:0] i_cfg_pattern,
    input  logic             i_step,
    output t_blink_res       o_res
);

    logic [PAT_W-1:0]   r_pattern;
    t_blink_cnt         r_cnt;
    t_blink_cnt         n_cnt;
    logic [BLINK_CNT_W:0] cnt_inc;

    assign cnt_inc = {1'b0, r_cnt} + 1'b1;

    always_comb begin
        n_cnt             = r_cnt;
        o_res.led_on      = 1'b1;
        o_res.period_done = 1'b0;
        if (r_pattern < PAT_STEADY) begin
            o_res.led_on = lit_at(r_pattern, r_cnt);
            if (cnt_inc >= period_of(r_pattern)) begin
                n_cnt             = '0;
                o_res.period_done = 1'b1;
            end else begin
                n_cnt = cnt_inc[BLINK_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_cnt     <= '0;
        end else if (i_cfg_wr) begin
            r_pattern <= i_cfg_pattern;
            r_cnt     <= '0;
        end else if (i_step) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### sv/bdl_outbuf.sv
// ----------------------------------------------------------------------------
// bdl_outbuf
// Result register with a skid stage, so the input side can take one more item
// while the head result waits to be taken.
// ----------------------------------------------------------------------------
module bdl_outbuf import bdl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result r_head;
    t_result r_skid;
    logic    r_head_vld;
    logic    r_skid_vld;
    logic    pop;

    assign pop     = r_head_vld && i_ready;
    assign o_space = !r_skid_vld;
    assign o_valid = r_head_vld;
    assign o_res   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop) begin
            if (r_skid_vld) begin
                r_head     <= r_skid;
                r_skid_vld <= 1'b0;
            end else if (i_push) begin
                r_head <= i_res;
            end else begin
                r_head_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_head_vld) begin
                r_head     <= i_res;
                r_head_vld <= 1'b1;
            end else begin
                r_skid     <= i_res;
                r_skid_vld <= 1'b1;
            end
        end
    end

endmodule

### sv/button_debounce_led_blinker.sv
// ----------------------------------------------------------------------------
// button_debounce_led_blinker
// Two-button debouncer with pattern-driven LED blinker, one item per tick unless stalled.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_button_one_level, i_button_two_level
//  out      output     o_out_valid / i_out_ready  o_led_on, o_button_one_press,
//                                                 o_button_two_press, o_wake
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_blink_pattern
//
// An item is taken every cycle while the output buffer has space; its result is
// registered in the head entry of a two-entry output buffer, or in its skid
// entry while the head waits. The debounce and blink state update at the
// accepting edge, and the input only stalls once both entries are full. Reset
// is synchronous and leaves all counters, states and the pattern at zero. The
// configuration port is always ready and a write also restarts the blink period.
// ----------------------------------------------------------------------------
module button_debounce_led_blinker import bdl_pkg::*; #(
    parameter int unsigned DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_button_one_level,
    input  logic             i_button_two_level,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_led_on,
    output logic             o_button_one_press,
    output logic             o_button_two_press,
    output logic             o_wake,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PAT_W-1:0] i_cfg_blink_pattern
);

    logic       step;
    logic       press_one;
    logic       press_two;
    logic       space;
    t_blink_res blink_res;
    t_result    res;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = space;
    assign step        = i_in_valid && space;

    bdl_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_deb_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_level (i_button_one_level),
        .o_press (press_one)
    );

    bdl_debounce #(.DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_deb_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_level (i_button_two_level),
        .o_press (press_two)
    );

    bdl_blink u_blink (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr      (i_cfg_valid),
        .i_cfg_pattern (i_cfg_blink_pattern),
        .i_step        (step),
        .o_res         (blink_res)
    );

    always_comb begin
        res.led_on           = blink_res.led_on;
        res.button_one_press = press_one;
        res.button_two_press = press_two;
        res.wake             = press_two | blink_res.period_done;
    end

    bdl_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_led_on           = out_res.led_on;
    assign o_button_one_press = out_res.button_one_press;
    assign o_button_two_press = out_res.button_two_press;
    assign o_wake             = out_res.wake;

endmodule
